// ===== src/rdt_pkg.sv =====
// ----------------------------------------------------------------------------
// Ring diagnosis table package
// Shared widths, codes, state encoding and the reset contents of a view row.
// ----------------------------------------------------------------------------
package rdt_pkg;

   localparam int MAX_NODES = 8;
   localparam int MIN_NODES = 5;
   localparam int NODE_W    = $clog2(MAX_NODES);
   localparam int COUNT_W   = 4;
   localparam int ENTRY_W   = 2;
   localparam int ROW_W     = ENTRY_W * MAX_NODES;
   localparam int SUSPECT_W = 3;

   typedef logic [NODE_W-1:0]    node_type;
   typedef logic [COUNT_W-1:0]   count_type;
   typedef logic [ROW_W-1:0]     row_type;
   typedef logic [SUSPECT_W-1:0] suspect_type;

   // View entry encoding.
   localparam logic [ENTRY_W-1:0] VIEW_CORRECT = 2'd0;
   localparam logic [ENTRY_W-1:0] VIEW_FAULTY  = 2'd1;
   localparam logic [ENTRY_W-1:0] VIEW_UNKNOWN = 2'd2;

   typedef enum logic [1:0] {
      OP_TEST    = 2'd0,
      OP_FAIL    = 2'd1,
      OP_RECOVER = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      CODE_FOUND   = 3'd0,
      CODE_ALONE   = 3'd1,
      CODE_FAULTY  = 3'd2,
      CODE_UPDATED = 3'd3,
      CODE_RANGE   = 3'd4
   } code_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_LOAD,
      ST_WALK,
      ST_COPY,
      ST_WRITE,
      ST_RESP
   } state_type;

   // Request from the sequencer to the view store.
   typedef struct packed {
      logic     wr_en;
      node_type wr_addr;
      row_type  wr_row;
      logic     rd_en;
      node_type rd_addr;
   } store_req_type;

   // A row that was never written: own entry correct, all others unknown.
   function automatic row_type reset_row(input node_type who);
      row_type row;
      row = '0;
      for (int i = 0; i < MAX_NODES; i++) begin
         row[i*ENTRY_W +: ENTRY_W] = (NODE_W'(i) == who) ? VIEW_CORRECT : VIEW_UNKNOWN;
      end
      return row;
   endfunction

endpackage

// ===== src/rdt_view_store.sv =====
// ----------------------------------------------------------------------------
// Ring diagnosis view store
// One row per node, one write and one registered read a cycle. A row that
// was never written reads as its reset contents.
// ----------------------------------------------------------------------------
module rdt_view_store
   import rdt_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  store_req_type store_req,
   output row_type       rd_row
);

   row_type                view_mem [MAX_NODES];
   logic [MAX_NODES-1:0]   row_valid_ff;
   row_type                rd_data_ff;
   logic                   rd_valid_ff;
   node_type               rd_addr_ff;

   // Row memory with its registered read word.
   always_ff @(posedge clock) begin
      if (store_req.wr_en) begin
         view_mem[store_req.wr_addr] <= store_req.wr_row;
      end
      if (store_req.rd_en) begin
         rd_data_ff  <= view_mem[store_req.rd_addr];
         rd_valid_ff <= row_valid_ff[store_req.rd_addr];
         rd_addr_ff  <= store_req.rd_addr;
      end
   end

   // A row becomes valid on its first write.
   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
      end else if (store_req.wr_en) begin
         row_valid_ff[store_req.wr_addr] <= 1'b1;
      end
   end

   // Rows never written show their reset contents.
   assign rd_row = rd_valid_ff ? rd_data_ff : reset_row(rd_addr_ff);

endmodule

// ===== src/ring_diagnosis_table.sv =====
// ----------------------------------------------------------------------------
// Ring diagnosis table
// Keeps a fault flag and a view row per node. A test walks the ring from the
// tester's successor with one shared ring-step unit, one node per cycle.
// ----------------------------------------------------------------------------
// A node out of range is answered in the cycle after accept; fail, recover
// or a faulty tester pass through read and load, and a test through read,
// load, ring walk, any row copy and row write. Walk and copy share one
// pointer and one modulo-n stepper, one entry per cycle, with n the node
// count in use. Busy stays high through the strobe cycle.
// Operation 3 leaves the block idle and gives no response. The response
// cannot be stalled. Synchronous reset: every node correct, node count 8.
module ring_diagnosis_table
   import rdt_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   // Request channel
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_operation,
   input  logic [2:0]        req_node,
   // Response channel
   output logic              rsp_strobe,
   output logic [2:0]        rsp_result_code,
   output logic [2:0]        rsp_correct_node,
   output logic [2:0]        rsp_suspects_marked,
   output logic [15:0]       rsp_view_row,
   // Configuration channel
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [3:0]        csr_node_count
);

   state_type            state_ff, state_in;
   op_type               op_ff, op_in;
   node_type             who_ff, who_in;
   node_type             ptr_ff, ptr_in;
   suspect_type          count_ff, count_in;
   row_type              row_ff, row_in;
   code_type             code_ff, code_in;
   node_type             correct_ff, correct_in;
   logic [MAX_NODES-1:0] faulty_ff, faulty_in;
   count_type            node_count_ff;

   count_type            active_count;
   node_type             step_src;
   node_type             step_next;
   logic                 accept;
   op_type               req_op;
   store_req_type        store_req;
   row_type              rd_row;

   assign accept = start && !busy;
   assign req_op = op_type'(req_operation);

   // Node count in use, held to the supported range.
   always_comb begin
      if (node_count_ff < COUNT_W'(MIN_NODES)) begin
         active_count = COUNT_W'(MIN_NODES);
      end else if (node_count_ff > COUNT_W'(MAX_NODES)) begin
         active_count = COUNT_W'(MAX_NODES);
      end else begin
         active_count = node_count_ff;
      end
   end

   // Shared ring stepper: the successor of a node modulo the node count.
   assign step_src  = (state_ff == ST_LOAD) ? who_ff : ptr_ff;
   assign step_next = ((COUNT_W'(step_src) + COUNT_W'(1)) == active_count) ?
                      '0 : step_src + NODE_W'(1);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_op != OP_NONE) begin
               if (COUNT_W'(req_node) >= active_count) begin
                  state_in = ST_RESP;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (op_ff != OP_TEST || faulty_ff[who_ff]) begin
               state_in = ST_RESP;
            end else begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (ptr_ff == who_ff) begin
               state_in = ST_WRITE;
            end else if (!faulty_ff[ptr_ff]) begin
               state_in = ST_COPY;
            end
         end
         ST_COPY: begin
            if (ptr_ff == who_ff) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath next values and store requests.
   always_comb begin
      op_in      = op_ff;
      who_in     = who_ff;
      ptr_in     = ptr_ff;
      count_in   = count_ff;
      row_in     = row_ff;
      code_in    = code_ff;
      correct_in = correct_ff;
      faulty_in  = faulty_ff;
      store_req  = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in      = req_op;
               who_in     = req_node;
               code_in    = CODE_RANGE;
               correct_in = '0;
               count_in   = '0;
               row_in     = '0;
            end
         end
         ST_READ: begin
            store_req.rd_en   = 1'b1;
            store_req.rd_addr = who_ff;
         end
         ST_LOAD: begin
            row_in     = rd_row;
            correct_in = who_ff;
            count_in   = '0;
            ptr_in     = step_next;
            if (op_ff == OP_FAIL || op_ff == OP_RECOVER) begin
               faulty_in[who_ff] = (op_ff == OP_FAIL);
               code_in           = CODE_UPDATED;
            end else if (faulty_ff[who_ff]) begin
               code_in = CODE_FAULTY;
            end
         end
         ST_WALK: begin
            if (ptr_ff == who_ff) begin
               code_in    = CODE_ALONE;
               correct_in = who_ff;
            end else if (faulty_ff[ptr_ff]) begin
               // Suspect: mark it and move on.
               row_in[{ptr_ff, 1'b0} +: ENTRY_W] = VIEW_FAULTY;
               count_in = count_ff + SUSPECT_W'(1);
               ptr_in   = step_next;
            end else begin
               // First correct node: fetch its row for the copy.
               row_in[{ptr_ff, 1'b0} +: ENTRY_W] = VIEW_CORRECT;
               code_in           = CODE_FOUND;
               correct_in        = ptr_ff;
               ptr_in            = step_next;
               store_req.rd_en   = 1'b1;
               store_req.rd_addr = ptr_ff;
            end
         end
         ST_COPY: begin
            if (ptr_ff != who_ff) begin
               row_in[{ptr_ff, 1'b0} +: ENTRY_W] = rd_row[{ptr_ff, 1'b0} +: ENTRY_W];
               ptr_in = step_next;
            end
         end
         ST_WRITE: begin
            store_req.wr_en   = 1'b1;
            store_req.wr_addr = who_ff;
            store_req.wr_row  = row_ff;
         end
         ST_RESP: begin
         end
         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         faulty_ff     <= '0;
         node_count_ff <= COUNT_W'(MAX_NODES);
      end else begin
         state_ff  <= state_in;
         faulty_ff <= faulty_in;
         if (csr_valid && csr_ready) begin
            node_count_ff <= csr_node_count;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      who_ff     <= who_in;
      ptr_ff     <= ptr_in;
      count_ff   <= count_in;
      row_ff     <= row_in;
      code_ff    <= code_in;
      correct_ff <= correct_in;
   end

   rdt_view_store u_view_store (
      .clock     (clock),
      .reset     (reset),
      .store_req (store_req),
      .rd_row    (rd_row)
   );

   // Port outputs.
   assign busy                = (state_ff != ST_IDLE);
   assign csr_ready           = !busy;
   assign rsp_strobe          = (state_ff == ST_RESP);
   assign rsp_result_code     = code_ff;
   assign rsp_correct_node    = correct_ff;
   assign rsp_suspects_marked = count_ff;
   assign rsp_view_row        = row_ff;

   // A response word always returns the block to idle.
   assert property (@(posedge clock) disable iff (reset) rsp_strobe |=> !busy)
      else $error("block still busy after a response word");

   // The ring pointer stays inside the ring in use.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK || state_ff == ST_COPY) |-> (COUNT_W'(ptr_ff) < active_count))
      else $error("ring pointer outside the active ring");

   // A found node is never the tester itself.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && code_ff == CODE_FOUND) |-> (correct_ff != who_ff))
      else $error("found node equals the tester");

   // Only a test marks suspects.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && code_ff != CODE_FOUND && code_ff != CODE_ALONE) |-> (count_ff == '0))
      else $error("suspects reported for an item that is not a test");

endmodule

// ===== verif/ring_diagnosis_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ring diagnosis checker
// Watches the request, response and register channels of the ring diagnosis
// table. It keeps its own fault flags, view rows and node count. For every
// accepted request word it computes the awaited response. Each response word
// is then compared field by field with the oldest awaited one.
// ----------------------------------------------------------------------------
module ring_diagnosis_checker
   import rdt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [1:0]  req_operation,
   input  logic [2:0]  req_node,
   input  logic        rsp_strobe,
   input  logic [2:0]  rsp_result_code,
   input  logic [2:0]  rsp_correct_node,
   input  logic [2:0]  rsp_suspects_marked,
   input  logic [15:0] rsp_view_row,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [3:0]  csr_node_count,
   output int          mismatch_count,
   output int          outstanding
);

   // One awaited response word.
   typedef struct packed {
      code_type    code;
      node_type    found;
      suspect_type suspects;
      row_type     row;
   } diag_report_type;

   diag_report_type awaited_reports[$];
   logic            node_down [MAX_NODES];
   row_type         views [MAX_NODES];
   count_type       ring_size_reg;
   int              errors = 0;

   // Node count in use, clamped to the supported ring sizes.
   function automatic int ring_size();
      int n;
      n = int'(ring_size_reg);
      if (n < MIN_NODES) n = MIN_NODES;
      if (n > MAX_NODES) n = MAX_NODES;
      return n;
   endfunction

   // Every node correct; each row knows only its own node.
   task automatic clear_state();
      ring_size_reg = count_type'(MAX_NODES);
      for (int r = 0; r < MAX_NODES; r++) begin
         node_down[r] = 1'b0;
         for (int i = 0; i < MAX_NODES; i++) begin
            views[r][i*ENTRY_W +: ENTRY_W] = (r == i) ? VIEW_CORRECT : VIEW_UNKNOWN;
         end
      end
      awaited_reports.delete();
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("MISMATCH at %0t: %s, got 0x%0h, expected 0x%0h", $time, what, got, want);
      errors++;
   endtask

   // Apply one request word to the model state and queue its response.
   task automatic run_diagnosis(input op_type op, input node_type who);
      int              n;
      int              probe;
      int              walk;
      int              hits;
      diag_report_type rep;
      n = ring_size();
      rep = '0;
      if (op == OP_NONE) return;
      if (int'(who) >= n) begin
         rep.code = CODE_RANGE;
      end else if (op == OP_FAIL || op == OP_RECOVER) begin
         node_down[who] = (op == OP_FAIL);
         rep.code = CODE_UPDATED;
         rep.found = who;
         rep.row = views[who];
      end else if (node_down[who]) begin
         rep.code = CODE_FAULTY;
         rep.found = who;
         rep.row = views[who];
      end else begin
         // Mark faulty successors until the first correct one.
         hits = 0;
         probe = (int'(who) + 1) % n;
         while (probe != int'(who) && node_down[probe]) begin
            views[who][probe*ENTRY_W +: ENTRY_W] = VIEW_FAULTY;
            hits++;
            probe = (probe + 1) % n;
         end
         if (probe != int'(who)) begin
            // Take over the correct node's view of the rest of the ring.
            views[who][probe*ENTRY_W +: ENTRY_W] = VIEW_CORRECT;
            walk = (probe + 1) % n;
            while (walk != int'(who)) begin
               views[who][walk*ENTRY_W +: ENTRY_W] = views[probe][walk*ENTRY_W +: ENTRY_W];
               walk = (walk + 1) % n;
            end
            rep.code = CODE_FOUND;
            rep.found = node_type'(probe);
         end else begin
            rep.code = CODE_ALONE;
            rep.found = who;
         end
         rep.suspects = (hits > 7) ? suspect_type'(7) : suspect_type'(hits);
         rep.row = views[who];
      end
      awaited_reports.push_back(rep);
   endtask

   task automatic check_response();
      diag_report_type rep;
      if (awaited_reports.size() == 0) begin
         report_mismatch("response word with nothing awaited", rsp_result_code, 0);
         return;
      end
      rep = awaited_reports.pop_front();
      if (rsp_result_code !== rep.code)
         report_mismatch("result_code", rsp_result_code, rep.code);
      if (rsp_correct_node !== rep.found)
         report_mismatch("correct_node", rsp_correct_node, rep.found);
      if (rsp_suspects_marked !== rep.suspects)
         report_mismatch("suspects_marked", rsp_suspects_marked, rep.suspects);
      if (rsp_view_row !== rep.row)
         report_mismatch("view_row", rsp_view_row, rep.row);
   endtask

   // Channels are sampled at the clock edge that completes each handshake.
   always @(posedge clock) begin
      if (reset) begin
         clear_state();
      end else begin
         if (csr_valid && csr_ready) ring_size_reg = csr_node_count;
         if (rsp_strobe) check_response();
         if (start && !busy) run_diagnosis(op_type'(req_operation), req_node);
      end
      mismatch_count <= errors;
      outstanding <= awaited_reports.size();
   end

endmodule

// ===== verif/tb_ring_diagnosis_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ring diagnosis table testbench
// Drives directed and random request words into the ring diagnosis table
// over several node counts, with random gaps on the request side. A checker
// beside the block predicts and compares every response word.
// ----------------------------------------------------------------------------
module tb_ring_diagnosis_table;
   import rdt_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_WORDS = 1950;
   localparam int PHASES       = 6;
   localparam int PHASE_WORDS  = RANDOM_WORDS / PHASES;
   localparam int SETTLE_WAIT  = 24;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_operation = OP_NONE;
   logic [2:0]  req_node = '0;
   logic        rsp_strobe;
   logic [2:0]  rsp_result_code;
   logic [2:0]  rsp_correct_node;
   logic [2:0]  rsp_suspects_marked;
   logic [15:0] rsp_view_row;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [3:0]  csr_node_count = '0;
   int          mismatch_count;
   int          outstanding;
   int          cycles = 0;
   bit          idle_on = 1'b0;

   always #2 clock = ~clock;

   ring_diagnosis_table u_top (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_operation       (req_operation),
      .req_node            (req_node),
      .rsp_strobe          (rsp_strobe),
      .rsp_result_code     (rsp_result_code),
      .rsp_correct_node    (rsp_correct_node),
      .rsp_suspects_marked (rsp_suspects_marked),
      .rsp_view_row        (rsp_view_row),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_node_count      (csr_node_count)
   );

   ring_diagnosis_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_operation       (req_operation),
      .req_node            (req_node),
      .rsp_strobe          (rsp_strobe),
      .rsp_result_code     (rsp_result_code),
      .rsp_correct_node    (rsp_correct_node),
      .rsp_suspects_marked (rsp_suspects_marked),
      .rsp_view_row        (rsp_view_row),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_node_count      (csr_node_count),
      .mismatch_count      (mismatch_count),
      .outstanding         (outstanding)
   );

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Present one request word and hold it until the block takes it.
   task automatic issue(input op_type op, input int who);
      int gap;
      start <= 1'b1;
      req_operation <= op;
      req_node <= 3'(who);
      @(posedge clock);
      while (busy) @(posedge clock);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 9);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Let every awaited response arrive and the block fall idle.
   task automatic settle();
      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   task automatic write_ring_size(input count_type value);
      csr_valid <= 1'b1;
      csr_node_count <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      count_type phase_sizes [PHASES];
      op_type    op;
      int        sent;
      int        fail_share;
      int        pick;
      phase_sizes = '{4'd0, 4'd15, 4'd5, 4'd6, 4'd7, 4'd8};
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed words on the full ring of eight.
      issue(OP_TEST, 0);
      issue(OP_TEST, 7);
      issue(OP_FAIL, 1);
      issue(OP_FAIL, 2);
      issue(OP_FAIL, 3);
      issue(OP_TEST, 0);
      issue(OP_TEST, 2);
      issue(OP_FAIL, 4);
      issue(OP_FAIL, 6);
      issue(OP_FAIL, 7);
      issue(OP_FAIL, 0);
      // Node 5 is now the only correct node in the ring.
      issue(OP_TEST, 5);
      issue(OP_NONE, 0);
      for (int i = 0; i < MAX_NODES; i++) issue(OP_RECOVER, i);
      settle();

      // Smallest ring: nodes past the end are rejected, tests wrap early.
      write_ring_size(4'd5);
      issue(OP_TEST, 7);
      issue(OP_FAIL, 5);
      issue(OP_TEST, 4);
      settle();

      // Random words over several ring sizes, calm in the last phase.
      for (int p = 0; p < PHASES; p++) begin
         write_ring_size(phase_sizes[p]);
         idle_on = (p != PHASES - 1);
         sent = 0;
         fail_share = 50;
         while (sent < PHASE_WORDS) begin
            if (sent % 64 == 0) fail_share = $urandom_range(25, 85);
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
               op = OP_TEST;
            end else if (pick < 95) begin
               op = ($urandom_range(0, 99) < fail_share) ? OP_FAIL : OP_RECOVER;
            end else begin
               op = OP_NONE;
            end
            issue(op, $urandom_range(0, 7));
            if (op != OP_NONE) sent++;
         end
         settle();
      end

      if (mismatch_count == 0 && outstanding == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
